/* rtl/esl_pkg.sv */
`timescale 1ns / 1ps

package esl_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       path_mode;
	} in_word_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] token_byte;
		logic       last_of_item;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_NORMAL      = 4'd0,
		ST_DOLLAR      = 4'd1,
		ST_CR          = 4'd2,
		ST_DOLLAR_CR   = 4'd3,
		ST_NAME        = 4'd4,
		ST_BRACE_FIRST = 4'd5,
		ST_BRACE_NAME  = 4'd6,
		ST_SKIP        = 4'd7,
		ST_DISCARD     = 4'd8
	} lex_state_t;

	localparam logic [2:0] KIND_TEXT  = 3'd0;
	localparam logic [2:0] KIND_NAME  = 3'd1;
	localparam logic [2:0] KIND_NEND  = 3'd2;
	localparam logic [2:0] KIND_END   = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Up to two tokens per byte, together with the state that the byte leaves.
	typedef struct packed {
		logic [1:0] count;
		out_word_t  tok0;
		out_word_t  tok1;
		lex_state_t state_nxt;
		logic       path_nxt;
		logic       start_nxt;
	} lex_res_t;

	function automatic logic is_name_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH;
	endfunction

	function automatic logic is_brace_char(input logic [7:0] c);
		return is_name_char(c) || c == CH_DOT;
	endfunction

endpackage

/* rtl/esl_lex_core.sv */
`timescale 1ns / 1ps

module esl_lex_core (
	input  esl_pkg::lex_state_t state,
	input  logic                path_latch,
	input  logic                at_start,
	input  esl_pkg::in_word_t   word,
	output esl_pkg::lex_res_t   res
);

	typedef struct packed {
		logic                emit;
		logic [2:0]          kind;
		logic [7:0]          tbyte;
		esl_pkg::lex_state_t state;
		logic                start;
	} nb_t;

	function automatic nb_t normal_byte(input logic [7:0] c, input logic path);
		nb_t r;
		r.emit  = 1'b0;
		r.kind  = esl_pkg::KIND_TEXT;
		r.tbyte = 8'h00;
		r.state = esl_pkg::ST_NORMAL;
		r.start = 1'b0;
		if (c == esl_pkg::CH_NUL) begin
			r.emit  = 1'b1;
			r.kind  = esl_pkg::KIND_END;
			r.start = 1'b1;
		end else if (c == esl_pkg::CH_DOLLAR) begin
			r.state = esl_pkg::ST_DOLLAR;
		end else if (c == esl_pkg::CH_CR) begin
			r.state = esl_pkg::ST_CR;
		end else if (c == esl_pkg::CH_LF) begin
			r.emit  = 1'b1;
			r.kind  = esl_pkg::KIND_END;
			r.state = esl_pkg::ST_DISCARD;
		end else if (path && (c == esl_pkg::CH_SPACE || c == esl_pkg::CH_COLON ||
				c == esl_pkg::CH_PIPE)) begin
			r.emit  = 1'b1;
			r.kind  = esl_pkg::KIND_END;
			r.state = esl_pkg::ST_DISCARD;
		end else begin
			r.emit  = 1'b1;
			r.tbyte = c;
		end
		return r;
	endfunction

	logic [7:0] c;
	logic       path;
	logic       fail;
	nb_t        nb;
	logic       use_nb;

	assign c    = word.char_in;
	assign path = at_start ? word.path_mode : path_latch;
	assign nb   = normal_byte(c, path);

	always_comb begin
		res           = '0;
		res.state_nxt = state;
		res.path_nxt  = path;
		res.start_nxt = 1'b0;
		fail          = 1'b0;
		use_nb        = 1'b0;
		case (state)
			esl_pkg::ST_DOLLAR: begin
				if (esl_pkg::is_name_char(c)) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NAME;
					res.tok0.token_byte = c;
					res.state_nxt      = esl_pkg::ST_NAME;
				end else if (c == esl_pkg::CH_LF) begin
					res.state_nxt = esl_pkg::ST_SKIP;
				end else if (c == esl_pkg::CH_CR) begin
					res.state_nxt = esl_pkg::ST_DOLLAR_CR;
				end else if (c == esl_pkg::CH_SPACE || c == esl_pkg::CH_DOLLAR ||
						c == esl_pkg::CH_COLON) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_TEXT;
					res.tok0.token_byte = c;
					res.state_nxt      = esl_pkg::ST_NORMAL;
				end else if (c == esl_pkg::CH_LBRACE) begin
					res.state_nxt = esl_pkg::ST_BRACE_FIRST;
				end else begin
					fail = 1'b1;
				end
			end
			esl_pkg::ST_CR: begin
				if (c == esl_pkg::CH_LF) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_END;
					res.state_nxt      = esl_pkg::ST_DISCARD;
				end else begin
					fail = 1'b1;
				end
			end
			esl_pkg::ST_DOLLAR_CR: begin
				if (c == esl_pkg::CH_LF) begin
					res.state_nxt = esl_pkg::ST_SKIP;
				end else begin
					fail = 1'b1;
				end
			end
			esl_pkg::ST_NAME: begin
				if (esl_pkg::is_name_char(c)) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NAME;
					res.tok0.token_byte = c;
				end else begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NEND;
					use_nb             = 1'b1;
				end
			end
			esl_pkg::ST_BRACE_FIRST: begin
				if (esl_pkg::is_brace_char(c)) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NAME;
					res.tok0.token_byte = c;
					res.state_nxt      = esl_pkg::ST_BRACE_NAME;
				end else begin
					fail = 1'b1;
				end
			end
			esl_pkg::ST_BRACE_NAME: begin
				if (esl_pkg::is_brace_char(c)) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NAME;
					res.tok0.token_byte = c;
				end else if (c == esl_pkg::CH_RBRACE) begin
					res.count          = 2'd1;
					res.tok0.token_kind = esl_pkg::KIND_NEND;
					res.state_nxt      = esl_pkg::ST_NORMAL;
				end else begin
					fail = 1'b1;
				end
			end
			esl_pkg::ST_SKIP: begin
				if (c != esl_pkg::CH_SPACE) begin
					use_nb = 1'b1;
				end
			end
			esl_pkg::ST_DISCARD: begin
				if (c == esl_pkg::CH_NUL) begin
					res.state_nxt = esl_pkg::ST_NORMAL;
					res.start_nxt = 1'b1;
				end
			end
			default: begin
				use_nb = 1'b1;
			end
		endcase

		if (fail) begin
			res.count          = 2'd1;
			res.tok0.token_kind = esl_pkg::KIND_ERROR;
			res.tok0.token_byte = 8'h00;
			if (c == esl_pkg::CH_NUL) begin
				res.state_nxt = esl_pkg::ST_NORMAL;
				res.start_nxt = 1'b1;
			end else begin
				res.state_nxt = esl_pkg::ST_DISCARD;
			end
		end

		if (use_nb) begin
			res.state_nxt = nb.state;
			res.start_nxt = nb.start;
			if (nb.emit) begin
				if (res.count == 2'd0) begin
					res.count          = 2'd1;
					res.tok0.token_kind = nb.kind;
					res.tok0.token_byte = nb.tbyte;
				end else begin
					res.count          = 2'd2;
					res.tok1.token_kind = nb.kind;
					res.tok1.token_byte = nb.tbyte;
				end
			end
		end

		res.tok0.last_of_item = (res.count == 2'd1);
		res.tok1.last_of_item = (res.count == 2'd2);
	end

endmodule

/* rtl/eval_string_lexer.sv */
`timescale 1ns / 1ps
// A byte is held in the input register and lexed there; its tokens go to the token queue.
// Throughput: one byte per cycle while the token queue has room; the token port delivers
// one word per cycle while token_ready is high. A byte is held back, whatever its token
// count, once four words wait in the four-word token queue, or three with none leaving.
// Reset: lexer in normal text state, queue empty, and the next byte latches path mode.

module eval_string_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  esl_pkg::in_word_t  byte_word,
	output logic               token_valid,
	input  logic               token_ready,
	output esl_pkg::out_word_t token_word
);

	logic                valid_s1;
	esl_pkg::in_word_t   word_s1;
	esl_pkg::lex_state_t state_q;
	logic                path_q;
	logic                start_q;
	esl_pkg::lex_res_t   res;

	esl_pkg::out_word_t  queue_q [4];
	logic [1:0]          wr_ptr_q;
	logic [1:0]          rd_ptr_q;
	logic [2:0]          count_q;

	logic                pop;
	logic                space_ok;
	logic                advance;
	logic [1:0]          push_n;

	esl_lex_core u_core (
		.state      (state_q),
		.path_latch (path_q),
		.at_start   (start_q),
		.word       (word_s1),
		.res        (res)
	);

	assign pop        = token_valid && token_ready;
	assign space_ok   = (count_q <= 3'd2) || (count_q == 3'd3 && pop);
	assign advance    = valid_s1 && space_ok;
	assign byte_ready = !valid_s1 || advance;
	assign push_n     = advance ? res.count : 2'd0;

	assign token_valid = (count_q != 3'd0);
	assign token_word  = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esl_pkg::ST_NORMAL;
			path_q  <= 1'b0;
			start_q <= 1'b1;
		end else if (advance) begin
			state_q <= res.state_nxt;
			path_q  <= res.path_nxt;
			start_q <= res.start_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res.tok0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res.tok1;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("token queue holds more than four words");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !space_ok |=> valid_s1 && $stable(word_s1))
		else $error("stalled byte lost before it was lexed");

	a_pair_queued: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_word.last_of_item |-> count_q >= 3'd2)
		else $error("first token of a pair shown without its partner queued");

	a_discard_mid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == esl_pkg::ST_DISCARD |-> !start_q)
		else $error("discard state at the start of a string");

endmodule
